@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle while reset is low.
`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle while reset is low.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ttt_pkg.sv @@
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned DELAY_W     = 32;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned US_PER_MS_W = 10;
  localparam int unsigned OFS_W       = DELAY_W + US_PER_MS_W;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_PRIME  = 2'd2,
    KIND_REMOVE = 2'd3
  } ttt_kind_t;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_INSERT = 2'd1,
    OP_PRIME  = 2'd2,
    OP_REMOVE = 2'd3
  } ttt_op_t;

  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_CLEAR       = 2'd1,
    ACT_MARK_ACTIVE = 2'd2,
    ACT_MARK_IDLE   = 2'd3
  } ttt_action_t;

  // One table operation as it travels down the cell chain.
  typedef struct packed {
    ttt_op_t              op;
    logic [ADDR_W-1:0]    key;
    logic                 delay_zero;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    cand;        // new deadline for a nonzero delay
    logic                 claimed;     // some cell took or matched it
    logic                 was_active;  // matched entry was active
    logic [TIME_W-1:0]    diff;        // deadline - now of matched entry
  } ttt_item_t;

endpackage

@@ rtl/core/ttt_if.sv @@
`timescale 1ns / 1ps

interface ttt_in_if import ttt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [ADDR_W-1:0]  task_address;
  logic [ADDR_W-1:0]  handler_address;
  logic [DELAY_W-1:0] delay_count;

  modport source (output valid, kind, task_address, handler_address, delay_count,
                  input ready);
  modport sink   (input valid, kind, task_address, handler_address, delay_count,
                  output ready);
endinterface

interface ttt_out_if import ttt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               matched;
  logic [1:0]         record_action;
  logic [COUNT_W-1:0] remaining_count;
  logic               table_full;

  modport source (output valid, matched, record_action, remaining_count, table_full,
                  input ready);
  modport sink   (input valid, matched, record_action, remaining_count, table_full,
                  output ready);
endinterface

@@ rtl/core/ttt_cell.sv @@
`timescale 1ns / 1ps

module ttt_cell import ttt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  ttt_item_t in_item,
  output logic      out_valid,
  output ttt_item_t out_item,
  output logic      used
);

  logic              valid_r;
  logic              used_r;
  logic              active_r;
  logic [ADDR_W-1:0] key_r;
  logic [TIME_W-1:0] deadline_r;
  ttt_item_t         item_r;
  ttt_item_t         item_nxt;
  logic              hit;
  logic              take;
  logic [TIME_W-1:0] deadline_nxt;

  always_comb begin
    hit  = in_valid && used_r && !in_item.claimed && (in_item.key == key_r) &&
           (in_item.op == OP_PRIME || in_item.op == OP_REMOVE);
    take = in_valid && !used_r && !in_item.claimed && (in_item.op == OP_INSERT);

    item_nxt = in_item;
    if (hit) begin
      item_nxt.claimed    = 1'b1;
      item_nxt.was_active = active_r;
      item_nxt.diff       = deadline_r - in_item.now;
    end
    if (take) begin
      item_nxt.claimed = 1'b1;
    end

    // zero delay keeps the later of now and the old deadline
    if (in_item.delay_zero) begin
      deadline_nxt = (in_item.now > deadline_r) ? in_item.now : deadline_r;
    end else begin
      deadline_nxt = in_item.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      used_r   <= 1'b0;
      active_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
      if (take) begin
        used_r   <= 1'b1;
        active_r <= 1'b0;
      end
      if (hit && in_item.op == OP_PRIME) begin
        active_r <= 1'b1;
      end
      if (hit && in_item.op == OP_REMOVE) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
      if (take) begin
        key_r      <= in_item.key;
        deadline_r <= '0;
      end
      if (hit && in_item.op == OP_PRIME && !active_r) begin
        deadline_r <= deadline_nxt;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;
  assign used      = used_r;

endmodule

@@ rtl/core/ttt_tail.sv @@
`timescale 1ns / 1ps

module ttt_tail import ttt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  ttt_item_t in_item,
  output logic      in_ready,
  ttt_out_if.source out_ch
);

  localparam int unsigned DVD_W     = TIME_W;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned N_CHUNK   = DVD_W / CHUNK_W;
  localparam int unsigned STEP_W    = $clog2(N_CHUNK);
  localparam int unsigned REM_W     = US_PER_MS_W;
  localparam int unsigned X_W       = REM_W + CHUNK_W;
  localparam int unsigned RCP_SHIFT = X_W + REM_W;
  localparam int unsigned RCP_W     = X_W + 1;
  localparam int unsigned PROD_W    = X_W + RCP_W;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(N_CHUNK - 1);
  // ceil(2^RCP_SHIFT / 1000): exact quotient for every value below 2^X_W
  localparam logic [RCP_W-1:0]  RCP = RCP_W'(((64'd1 << RCP_SHIFT) + 64'(US_PER_MS) - 64'd1) /
                                             64'(US_PER_MS));

  typedef enum logic {
    T_PASS,
    T_DIVIDE
  } tail_state_t;

  tail_state_t        state_r;
  logic               out_valid_r;
  logic               matched_r;
  ttt_action_t        action_r;
  logic [COUNT_W-1:0] remaining_r;
  logic               full_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [REM_W-1:0]   rem_r;
  logic [COUNT_W-1:0] quo_r;
  logic [STEP_W-1:0]  step_r;

  logic               res_matched;
  ttt_action_t        res_action;
  logic               res_full;
  logic               live;
  logic               need_div;
  logic [COUNT_W-1:0] enc;
  logic [X_W-1:0]     div_x;
  logic [PROD_W-1:0]  div_prod;
  logic [CHUNK_W-1:0] div_q;
  logic [X_W-1:0]     div_back;
  logic [REM_W-1:0]   rem_nxt;
  logic [COUNT_W-1:0] quo_nxt;

  always_comb begin
    res_matched = in_item.claimed && (in_item.op == OP_PRIME || in_item.op == OP_REMOVE);
    res_full    = (in_item.op == OP_INSERT) && !in_item.claimed;
    case (in_item.op)
      OP_INSERT: res_action = in_item.claimed ? ACT_CLEAR : ACT_NONE;
      OP_PRIME:  res_action = (in_item.claimed && !in_item.was_active) ?
                              ACT_MARK_ACTIVE : ACT_NONE;
      OP_REMOVE: res_action = in_item.claimed ? ACT_MARK_IDLE : ACT_NONE;
      default:   res_action = ACT_NONE;
    endcase

    // past the deadline reads as zero; short waits go out as negated us
    live     = (in_item.op == OP_REMOVE) && in_item.claimed && in_item.was_active;
    need_div = live && !in_item.diff[TIME_W-1] && (in_item.diff[TIME_W-2:COUNT_W-1] != '0);
    if (!live || in_item.diff[TIME_W-1]) begin
      enc = '0;
    end else begin
      enc = COUNT_W'(0) - in_item.diff[COUNT_W-1:0];
    end

    // divide by 1000 one 16-bit chunk per cycle: reciprocal multiply of
    // remainder and chunk, then take back the quotient to get the remainder
    div_x    = {rem_r, dvd_r[DVD_W-1 -: CHUNK_W]};
    div_prod = PROD_W'(div_x) * PROD_W'(RCP);
    div_q    = div_prod[RCP_SHIFT +: CHUNK_W];
    div_back = X_W'(div_q) * X_W'(US_PER_MS);
    rem_nxt  = REM_W'(div_x - div_back);
    quo_nxt  = {quo_r[COUNT_W-CHUNK_W-1:0], div_q};
  end

  assign in_ready = (state_r == T_PASS) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_PASS;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        T_PASS: begin
          if (in_valid && in_ready) begin
            matched_r   <= res_matched;
            action_r    <= res_action;
            full_r      <= res_full;
            out_valid_r <= !need_div;
            if (need_div) begin
              state_r <= T_DIVIDE;
              dvd_r   <= in_item.diff;
              rem_r   <= '0;
              quo_r   <= '0;
              step_r  <= '0;
            end else begin
              remaining_r <= enc;
            end
          end else if (out_valid_r && out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        T_DIVIDE: begin
          dvd_r  <= {dvd_r[DVD_W-CHUNK_W-1:0], CHUNK_W'(0)};
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_LAST) begin
            remaining_r <= quo_nxt;
            out_valid_r <= 1'b1;
            state_r     <= T_PASS;
          end
        end
        default: state_r <= T_PASS;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.matched         = matched_r;
  assign out_ch.record_action   = action_r;
  assign out_ch.remaining_count = remaining_r;
  assign out_ch.table_full      = full_r;

endmodule

@@ rtl/core/timer_task_table_core.sv @@
`timescale 1ns / 1ps
// Timer task table: entries keyed by task address plus a microsecond clock.
// Input channel in_ch carries one operation per transfer: kind tick advances
// the clock by one, insert appends an idle entry, prime arms the first entry
// with the key, remove disarms it and reports the time left. A zero key makes
// insert, prime and remove do nothing. Output channel out_ch returns exactly one
// result per input transfer, in order.
// Each entry lives in one cell of a chain of TABLE_ENTRIES cells; an operation
// moves one cell per cycle while the chain advances, from the head and prep
// stages through every cell to the result register. A remove that finds at
// least 2^31 us left divides by 1000 at the end of the chain (one 16-bit chunk
// per cycle) and holds off input meanwhile. Otherwise one operation enters per
// cycle unless out_ch stalls. A stall on out_ch freezes the whole chain:
// in_ch.ready drops in the same cycle and every stage holds its contents.
// Reset (synchronous, rst_n low) clears the clock, empties every cell and
// drops all valid flags; no clearing pass is needed.

`include "assert_macros.svh"

module timer_task_table_core import ttt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  ttt_in_if.sink  in_ch,
  ttt_out_if.source out_ch
);

  // chain advance: the whole pipeline moves together
  logic              adv;
  logic              accept;

  logic [TIME_W-1:0] now_r;

  // head stage: decode and scale the delay
  logic              h_valid_r;
  ttt_item_t         h_item_r;
  ttt_item_t         h_item_nxt;
  ttt_op_t           head_op;
  logic [OFS_W-1:0]  ms_offset;
  logic [DELAY_W-1:0] neg_offset;
  logic [OFS_W-1:0]  offset;

  // prep stage: add the offset to the captured clock
  logic              p_valid_r;
  ttt_item_t         p_item_r;
  ttt_item_t         p_item_nxt;

  // links between cells
  ttt_item_t                link_item [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0]   link_valid;
  logic [TABLE_ENTRIES-1:0] used_vec;

  assign accept      = in_ch.valid && adv;
  assign in_ch.ready = adv;

  always_comb begin
    head_op = OP_NOP;
    if (in_ch.task_address != '0) begin
      unique case (in_ch.kind)
        KIND_INSERT: head_op = OP_INSERT;
        KIND_PRIME:  head_op = OP_PRIME;
        KIND_REMOVE: head_op = OP_REMOVE;
        default:     head_op = OP_NOP;
      endcase
    end

    // below 2^31: milliseconds; otherwise the negation counts microseconds
    ms_offset  = OFS_W'(in_ch.delay_count) * OFS_W'(US_PER_MS);
    neg_offset = DELAY_W'(0) - in_ch.delay_count;
    offset     = in_ch.delay_count[DELAY_W-1] ? OFS_W'(neg_offset) : ms_offset;

    h_item_nxt            = '0;
    h_item_nxt.op         = head_op;
    h_item_nxt.key        = in_ch.task_address;
    h_item_nxt.delay_zero = (in_ch.delay_count == '0);
    h_item_nxt.now        = now_r;
    h_item_nxt.cand       = TIME_W'(offset);

    p_item_nxt      = h_item_r;
    p_item_nxt.cand = h_item_r.now + h_item_r.cand;
  end

  // hold control state; advance the clock on each tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r     <= '0;
      h_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
    end else begin
      if (accept && in_ch.kind == KIND_TICK) begin
        now_r <= now_r + 64'd1;
      end
      if (adv) begin
        h_valid_r <= in_ch.valid;
        p_valid_r <= h_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_item_r <= h_item_nxt;
      p_item_r <= p_item_nxt;
    end
  end

  assign link_item[0]  = p_item_r;
  assign link_valid[0] = p_valid_r;

  // one cell per entry; the first free cell takes an insert, the first
  // used cell with the key takes a prime or remove
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ttt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (link_valid[g]),
      .in_item   (link_item[g]),
      .out_valid (link_valid[g+1]),
      .out_item  (link_item[g+1]),
      .used      (used_vec[g])
    );
  end

  // encode the result; an insert no cell took means the table is full
  ttt_tail u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (link_valid[TABLE_ENTRIES]),
    .in_item  (link_item[TABLE_ENTRIES]),
    .in_ready (adv),
    .out_ch   (out_ch)
  );

  // the chain moves only when the result register can take its output
  `ASSERT_IMPLIES(a_ready_needs_room, clk, rst_n, in_ch.ready,
                  !out_ch.valid || out_ch.ready, "input ready while result blocked")
  // a tick transfer advances the clock by exactly one
  `ASSERT_NEXT(a_tick_advances, clk, rst_n, accept && in_ch.kind == KIND_TICK,
               now_r == $past(now_r) + 64'd1, "tick did not advance the clock")
  // used cells always form a prefix of the chain
  `ASSERT_IMPLIES(a_used_prefix, clk, rst_n, 1'b1,
                  ((used_vec + TABLE_ENTRIES'(1)) & used_vec) == '0, "used cells not contiguous")

endmodule
